/* hw/rtl/lra_pkg.sv */
// ----------------------------------------------------------------------------
// lra_pkg
// shared types, codes and defaults for the lru register allocator
// ----------------------------------------------------------------------------
package lra_pkg;

    localparam int REGISTER_COUNT_DEF = 8;
    localparam int AGE_BITS_DEF       = 16;
    localparam int KEY_W              = 16;
    localparam int RIDX_W             = 3;
    localparam int MODE_W             = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACCESS = 2'd0,
        MODE_DEFINE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_DROP   = 2'd3
    } mode_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic drop;
        logic commit;
        logic flush_emit;
    } lra_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic none_valid;
        logic flush_last;
    } lra_status_t;

    // one result item
    typedef struct packed {
        logic [RIDX_W-1:0] reg_index;
        logic              hit;
        logic              load_needed;
        logic              writeback_valid;
        logic [KEY_W-1:0]  old_key;
        logic              entry_valid;
        logic              last;
    } lra_result_t;

endpackage

/* hw/rtl/lra_if.sv */
// ----------------------------------------------------------------------------
// lra_if
// request and result channels of the lru register allocator
// ----------------------------------------------------------------------------
interface lra_req_if;
    logic                       valid;
    logic                       ready;
    logic [lra_pkg::MODE_W-1:0] mode;
    logic [lra_pkg::KEY_W-1:0]  symbol_key;
    logic                       symbol_is_temp;

    modport source (output valid, output mode, output symbol_key, output symbol_is_temp,
                    input ready);
    modport sink   (input valid, input mode, input symbol_key, input symbol_is_temp,
                    output ready);
endinterface

interface lra_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lra_pkg::RIDX_W-1:0] reg_index;
    logic                       hit;
    logic                       load_needed;
    logic                       writeback_valid;
    logic [lra_pkg::KEY_W-1:0]  old_key;
    logic                       entry_valid;
    logic                       last;

    modport source (output valid, output reg_index, output hit, output load_needed,
                    output writeback_valid, output old_key, output entry_valid,
                    output last, input ready);
    modport sink   (input valid, input reg_index, input hit, input load_needed,
                    input writeback_valid, input old_key, input entry_valid,
                    input last, output ready);
endinterface

/* hw/rtl/lra_ctrl.sv */
// ----------------------------------------------------------------------------
// lra_ctrl
// sequencer: request intake, commit and flush listing
// ----------------------------------------------------------------------------
module lra_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [lra_pkg::MODE_W-1:0] in_mode,
    output logic                       in_ready,
    input  lra_pkg::lra_status_t       status,
    output lra_pkg::lra_cmd_t          cmd
);
    import lra_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_COMMIT = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(in_mode))
                        MODE_ACCESS, MODE_DEFINE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_COMMIT;
                        end
                        MODE_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            cmd.drop = 1'b1;
                        end
                    endcase
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (status.none_valid || status.flush_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/lra_dp.sv */
// ----------------------------------------------------------------------------
// lra_dp
// register file state, key match, victim tree and result register
// ----------------------------------------------------------------------------
module lra_dp #(
    parameter int REGISTER_COUNT = lra_pkg::REGISTER_COUNT_DEF,
    parameter int AGE_BITS       = lra_pkg::AGE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lra_pkg::MODE_W-1:0] in_mode,
    input  logic [lra_pkg::KEY_W-1:0]  in_key,
    input  logic                       in_temp,
    input  lra_pkg::lra_cmd_t          cmd,
    output lra_pkg::lra_status_t       status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output lra_pkg::lra_result_t       out_res
);
    import lra_pkg::*;

    localparam int IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int NP = 1 << IW;
    localparam int NODES = 2 * NP - 1;

    logic [REGISTER_COUNT-1:0] slot_valid_reg, slot_valid_next;
    logic [AGE_BITS-1:0]       slot_age_reg  [REGISTER_COUNT];
    logic [AGE_BITS-1:0]       slot_age_next [REGISTER_COUNT];
    logic [KEY_W-1:0]          slot_key_reg  [REGISTER_COUNT];
    logic [KEY_W-1:0]          slot_key_next [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] slot_temp_reg, slot_temp_next;

    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              temp_reg;
    logic              hit_reg;
    logic [IW-1:0]     chosen_reg;

    logic              out_valid_reg;
    lra_result_t       out_res_reg, out_res_next;

    // key match, lowest index first
    logic          hit_found;
    logic [IW-1:0] hit_idx;

    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = REGISTER_COUNT - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_key_reg[i] == in_key))
            begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
        end
    end

    // oldest-slot trees, left child wins a tie
    logic [AGE_BITS-1:0] fr_age [NODES];
    logic [IW-1:0]       fr_idx [NODES];
    logic                fr_ok  [NODES];
    logic [AGE_BITS-1:0] an_age [NODES];
    logic [IW-1:0]       an_idx [NODES];
    logic                an_ok  [NODES];
    logic [IW-1:0]       victim;

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            if (i < REGISTER_COUNT)
            begin
                fr_age[NP-1+i] = slot_age_reg[i];
                fr_ok[NP-1+i]  = !slot_valid_reg[i];
                an_ok[NP-1+i]  = 1'b1;
            end
            else
            begin
                fr_age[NP-1+i] = '0;
                fr_ok[NP-1+i]  = 1'b0;
                an_ok[NP-1+i]  = 1'b0;
            end
            an_age[NP-1+i] = fr_age[NP-1+i];
            fr_idx[NP-1+i] = IW'(i);
            an_idx[NP-1+i] = IW'(i);
        end
        for (int n = NP - 2; n >= 0; n--)
        begin
            if (fr_ok[2*n+1] && (!fr_ok[2*n+2] || (fr_age[2*n+1] >= fr_age[2*n+2])))
            begin
                fr_age[n] = fr_age[2*n+1];
                fr_idx[n] = fr_idx[2*n+1];
            end
            else
            begin
                fr_age[n] = fr_age[2*n+2];
                fr_idx[n] = fr_idx[2*n+2];
            end
            fr_ok[n] = fr_ok[2*n+1] || fr_ok[2*n+2];
            if (an_ok[2*n+1] && (!an_ok[2*n+2] || (an_age[2*n+1] >= an_age[2*n+2])))
            begin
                an_age[n] = an_age[2*n+1];
                an_idx[n] = an_idx[2*n+1];
            end
            else
            begin
                an_age[n] = an_age[2*n+2];
                an_idx[n] = an_idx[2*n+2];
            end
            an_ok[n] = an_ok[2*n+1] || an_ok[2*n+2];
        end
        victim = fr_ok[0] ? fr_idx[0] : an_idx[0];
    end

    // lowest held slot for flush listing
    logic [IW-1:0] first_idx;

    always_comb
    begin
        first_idx = '0;
        for (int i = REGISTER_COUNT - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i])
            begin
                first_idx = IW'(i);
            end
        end
    end

    // single read port into the slot state
    logic [IW-1:0]    rd_idx;
    logic             rd_valid;
    logic [KEY_W-1:0] rd_key;
    logic             rd_temp;

    assign rd_idx   = cmd.flush_emit ? first_idx : chosen_reg;
    assign rd_valid = slot_valid_reg[rd_idx];
    assign rd_key   = slot_key_reg[rd_idx];
    assign rd_temp  = slot_temp_reg[rd_idx];

    logic             out_free;
    logic             do_touch;
    logic             commit_wb;

    assign out_free  = !out_valid_reg || out_ready;
    assign commit_wb = !hit_reg && rd_valid;
    assign do_touch  = cmd.commit && (!hit_reg || (mode_t'(mode_reg) == MODE_DEFINE));

    assign status.out_free   = out_free;
    assign status.none_valid = (slot_valid_reg == '0);
    assign status.flush_last =
        ((slot_valid_reg & (slot_valid_reg - REGISTER_COUNT'(1))) == '0);

    // slot state update
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_temp_next  = slot_temp_reg;
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            slot_age_next[i] = slot_age_reg[i];
            slot_key_next[i] = slot_key_reg[i];
        end
        if (cmd.drop)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                if (slot_valid_reg[i])
                begin
                    slot_age_next[i] = '0;
                end
            end
            slot_valid_next = '0;
        end
        if (cmd.commit)
        begin
            if (!hit_reg)
            begin
                slot_valid_next[chosen_reg] = 1'b1;
                slot_key_next[chosen_reg]   = key_reg;
            end
        end
        if (do_touch)
        begin
            // an access hit leaves the temporary mark alone
            slot_temp_next[chosen_reg] = temp_reg;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                if (IW'(i) == chosen_reg)
                begin
                    slot_age_next[i] = '0;
                end
                else if (slot_age_reg[i] != '1)
                begin
                    slot_age_next[i] = slot_age_reg[i] + AGE_BITS'(1);
                end
            end
        end
        if (cmd.flush_emit && (slot_valid_reg != '0))
        begin
            slot_valid_next[first_idx] = 1'b0;
            slot_age_next[first_idx]   = '0;
        end
    end

    // result formation
    always_comb
    begin
        out_res_next = '0;
        if (cmd.commit)
        begin
            out_res_next.reg_index       = RIDX_W'(chosen_reg);
            out_res_next.hit             = hit_reg;
            out_res_next.load_needed     = !hit_reg && (mode_t'(mode_reg) == MODE_ACCESS);
            out_res_next.writeback_valid = commit_wb;
            out_res_next.old_key         = commit_wb ? rd_key : '0;
            out_res_next.entry_valid     = 1'b1;
            out_res_next.last            = 1'b1;
        end
        else if (slot_valid_reg != '0)
        begin
            out_res_next.reg_index       = RIDX_W'(first_idx);
            out_res_next.writeback_valid = !rd_temp;
            out_res_next.old_key         = rd_key;
            out_res_next.entry_valid     = 1'b1;
            out_res_next.last            = status.flush_last;
        end
        else
        begin
            out_res_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                slot_age_reg[i] <= '0;
            end
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                slot_age_reg[i] <= slot_age_next[i];
            end
            if (cmd.commit || cmd.flush_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_temp_reg <= slot_temp_next;
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            slot_key_reg[i] <= slot_key_next[i];
        end
        if (cmd.capture)
        begin
            mode_reg   <= in_mode;
            key_reg    <= in_key;
            temp_reg   <= in_temp;
            hit_reg    <= hit_found;
            chosen_reg <= hit_found ? hit_idx : victim;
        end
        if (cmd.commit || cmd.flush_emit)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* hw/rtl/lru_register_allocator_unit.sv */
// ----------------------------------------------------------------------------
// lru_register_allocator_unit
// fully associative register allocator with lru replacement and flush
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------------
//   req     | in  | valid / ready | mode, symbol_key, symbol_is_temp
//   rsp     | out | valid / ready | reg_index, hit, load_needed,
//           |     |               | writeback_valid, old_key, entry_valid, last
//
// access and define: the request edge registers the key match and the
// oldest-slot pick, the commit cycle updates the slots and loads the
// result register
// flush gives one result per held register (at least one result) through the
// single read port, which lists one slot per cycle while the result register
// is free; reset empties the file and clears all ages at once, no sweep
// commit and flush listing stall while the result register holds an untaken
// result; a new request is taken while the last result still waits
//
module lru_register_allocator_unit #(
    parameter int REGISTER_COUNT = lra_pkg::REGISTER_COUNT_DEF,
    parameter int AGE_BITS       = lra_pkg::AGE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lra_req_if.sink   req,
    lra_rsp_if.source rsp
);
    import lra_pkg::*;

    lra_cmd_t    cmd;
    lra_status_t status;
    lra_result_t res;

    // sequencer: decides when to capture, commit, drop and list
    lra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot state, lookup logic and the result register
    lra_dp #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .AGE_BITS       (AGE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mode   (req.mode),
        .in_key    (req.symbol_key),
        .in_temp   (req.symbol_is_temp),
        .cmd       (cmd),
        .status    (status),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_res   (res)
    );

    // result fields onto the channel
    assign rsp.reg_index       = res.reg_index;
    assign rsp.hit             = res.hit;
    assign rsp.load_needed     = res.load_needed;
    assign rsp.writeback_valid = res.writeback_valid;
    assign rsp.old_key         = res.old_key;
    assign rsp.entry_valid     = res.entry_valid;
    assign rsp.last            = res.last;

endmodule

/* hw/rtl/lra_checker.sv */
// ----------------------------------------------------------------------------
// lra_checker
// port-level checks on the lru register allocator, bound to the top level
// ----------------------------------------------------------------------------
module lra_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic [lra_pkg::MODE_W-1:0] req_mode,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_hit,
    input logic                       rsp_load_needed,
    input logic                       rsp_writeback_valid,
    input logic [lra_pkg::KEY_W-1:0]  rsp_old_key,
    input logic                       rsp_entry_valid,
    input logic                       rsp_last
);
    import lra_pkg::*;

    // access or define always spends a commit cycle with requests held off
    a_commit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready &&
         ((req_mode == MODE_ACCESS) || (req_mode == MODE_DEFINE))) |=> !req_ready)
        else $error("request taken during commit cycle");

    // empty flush result is a bare last marker
    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_entry_valid) |->
        (rsp_last && !rsp_hit && !rsp_load_needed && !rsp_writeback_valid &&
         (rsp_old_key == '0)))
        else $error("malformed empty flush result");

    // a hit never loads or writes back
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_hit) |-> (!rsp_load_needed && !rsp_writeback_valid))
        else $error("hit with load or writeback");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
        (rsp_valid && $stable(rsp_old_key) && $stable(rsp_last)))
        else $error("result changed while stalled");

endmodule

bind lru_register_allocator_unit lra_checker u_lra_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_mode            (req.mode),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_hit             (rsp.hit),
    .rsp_load_needed     (rsp.load_needed),
    .rsp_writeback_valid (rsp.writeback_valid),
    .rsp_old_key         (rsp.old_key),
    .rsp_entry_valid     (rsp.entry_valid),
    .rsp_last            (rsp.last)
);
